// ===== design/lsfa_pkg.sv =====
// Shared types and constants for the line scan filter with auto exposure.
package lsfa_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int INDEX_W   = 7;
  localparam int ITV_W     = 16;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  localparam int LINE_PIXELS_DEF  = 128;
  localparam int WINDOW_FIRST_DEF = 10;
  localparam int WINDOW_LIMIT_DEF = 118;

  localparam logic [SAMPLE_W-1:0] MIN_CAP        = 10'd1000;
  localparam logic [ITV_W-1:0]    INTERVAL_START = 16'd20000;

  // divide by ten: x * ceil(2^19 / 10) >> 19, exact for x below 2^16
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam logic [SAMPLE_W-1:0] DARK_LEVEL_RST       = 10'd750;
  localparam logic [SAMPLE_W-1:0] BRIGHT_LEVEL_RST     = 10'd950;
  localparam logic [ITV_W-1:0]    INTERVAL_CEILING_RST = 16'd37000;
  localparam logic [ITV_W-1:0]    COARSE_FLOOR_RST     = 16'd24000;
  localparam logic [ITV_W-1:0]    FINE_FLOOR_RST       = 16'd2000;
  localparam logic [ITV_W-1:0]    FINE_STEP_RST        = 16'd500;
  localparam logic [ITV_W-1:0]    COARSE_STEP_RST      = 16'd1000;

  typedef enum logic [2:0] {
    REG_DARK_LEVEL       = 3'd0,
    REG_BRIGHT_LEVEL     = 3'd1,
    REG_INTERVAL_CEILING = 3'd2,
    REG_COARSE_FLOOR     = 3'd3,
    REG_FINE_FLOOR       = 3'd4,
    REG_FINE_STEP        = 3'd5,
    REG_COARSE_STEP      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dark_level;
    logic [SAMPLE_W-1:0] bright_level;
    logic [ITV_W-1:0]    interval_ceiling;
    logic [ITV_W-1:0]    coarse_floor;
    logic [ITV_W-1:0]    fine_floor;
    logic [ITV_W-1:0]    fine_step;
    logic [ITV_W-1:0]    coarse_step;
  } cfg_t;

endpackage

// ===== design/line_scan_filter_autoexposure.sv =====
// Top level: line scan readout with temporal smoothing, window min/max and auto exposure.
//
// Each accepted sample yields exactly one result, registered at each stage; one sample can
// be taken every cycle as long as results are taken. The line store is a ring of LINE_PIXELS
// cells that rotates one place per transaction, so the current pixel's old value always sits
// at the head cell; the smoothing multiply and the store write happen in the second stage,
// the exposure adjustment in the third. Reset clears the whole ring at once. Configuration
// goes through the APB port at byte address 4*index and must only change while idle.
module line_scan_filter_autoexposure #(
  parameter int LINE_PIXELS  = lsfa_pkg::LINE_PIXELS_DEF,
  parameter int WINDOW_FIRST = lsfa_pkg::WINDOW_FIRST_DEF,
  parameter int WINDOW_LIMIT = lsfa_pkg::WINDOW_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsfa_pkg::APB_AW-1:0]   paddr,
  input  logic [lsfa_pkg::APB_DW-1:0]   pwdata,
  output logic [lsfa_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lsfa_pkg::SAMPLE_W-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lsfa_pkg::INDEX_W-1:0]  pixel_index_o,
  output logic                          start_pulse_o,
  output logic [lsfa_pkg::SAMPLE_W-1:0] smoothed_pixel_o,
  output logic                          line_end_o,
  output logic [lsfa_pkg::SAMPLE_W-1:0] line_average_o,
  output logic [lsfa_pkg::ITV_W-1:0]    exposure_interval_o,
  output logic [lsfa_pkg::SAMPLE_W-1:0] window_min_o,
  output logic [lsfa_pkg::SAMPLE_W-1:0] window_max_o
);

  localparam int SW      = lsfa_pkg::SAMPLE_W;
  localparam int IDX_W   = $clog2(LINE_PIXELS);
  localparam int QS_RAW  = $clog2((1023 / LINE_PIXELS) + 1);
  localparam int QS_W    = (QS_RAW < 1) ? 1 : QS_RAW;
  localparam int RCP_SH  = SW + IDX_W;
  localparam int RCP_MUL = ((1 << RCP_SH) + LINE_PIXELS - 1) / LINE_PIXELS;
  localparam int RCP_W   = $clog2(RCP_MUL + 1);
  localparam int PROD_W  = SW + RCP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_PIXELS - 1);

  // configuration
  lsfa_pkg::cfg_t cfg_q, cfg_d;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (lsfa_pkg::reg_idx_e'(paddr[4:2]))
        lsfa_pkg::REG_DARK_LEVEL:       cfg_d.dark_level       = pwdata[SW-1:0];
        lsfa_pkg::REG_BRIGHT_LEVEL:     cfg_d.bright_level     = pwdata[SW-1:0];
        lsfa_pkg::REG_INTERVAL_CEILING: cfg_d.interval_ceiling = pwdata[15:0];
        lsfa_pkg::REG_COARSE_FLOOR:     cfg_d.coarse_floor     = pwdata[15:0];
        lsfa_pkg::REG_FINE_FLOOR:       cfg_d.fine_floor       = pwdata[15:0];
        lsfa_pkg::REG_FINE_STEP:        cfg_d.fine_step        = pwdata[15:0];
        lsfa_pkg::REG_COARSE_STEP:      cfg_d.coarse_step      = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lsfa_pkg::reg_idx_e'(paddr[4:2]))
      lsfa_pkg::REG_DARK_LEVEL:       prdata = 32'(cfg_q.dark_level);
      lsfa_pkg::REG_BRIGHT_LEVEL:     prdata = 32'(cfg_q.bright_level);
      lsfa_pkg::REG_INTERVAL_CEILING: prdata = 32'(cfg_q.interval_ceiling);
      lsfa_pkg::REG_COARSE_FLOOR:     prdata = 32'(cfg_q.coarse_floor);
      lsfa_pkg::REG_FINE_FLOOR:       prdata = 32'(cfg_q.fine_floor);
      lsfa_pkg::REG_FINE_STEP:        prdata = 32'(cfg_q.fine_step);
      lsfa_pkg::REG_COARSE_STEP:      prdata = 32'(cfg_q.coarse_step);
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_level       <= lsfa_pkg::DARK_LEVEL_RST;
      cfg_q.bright_level     <= lsfa_pkg::BRIGHT_LEVEL_RST;
      cfg_q.interval_ceiling <= lsfa_pkg::INTERVAL_CEILING_RST;
      cfg_q.coarse_floor     <= lsfa_pkg::COARSE_FLOOR_RST;
      cfg_q.fine_floor       <= lsfa_pkg::FINE_FLOOR_RST;
      cfg_q.fine_step        <= lsfa_pkg::FINE_STEP_RST;
      cfg_q.coarse_step      <= lsfa_pkg::COARSE_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline control: whole pipe moves when the output register is empty or being taken
  logic advance;
  logic out_valid_q;

  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = advance;
  assign out_valid_o = out_valid_q;

  // stage 1: register the sample and its quotient by the line length
  logic [PROD_W-1:0] qs_prod;
  logic              s1_valid_q;
  logic [SW-1:0]     s1_sample_q;
  logic [QS_W-1:0]   s1_qs_q;

  assign qs_prod = PROD_W'(sample_i) * PROD_W'(RCP_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_sample_q <= sample_i;
      s1_qs_q     <= qs_prod[RCP_SH +: QS_W];
    end
  end

  // stage 2: smoothing, line store ring, line statistics
  logic              step;
  logic [SW-1:0]     ring [LINE_PIXELS];
  logic [13:0]       mac;
  logic [29:0]       div_prod;
  logic [SW-1:0]     smooth;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              is_end;
  logic              in_win;
  logic [SW-1:0]     run_min_q, run_min_d, win_min;
  logic [SW-1:0]     run_max_q, run_max_d, win_max;
  logic [SW-1:0]     rem_full;
  logic [IDX_W:0]    rem_sum;
  logic              rem_carry;
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [SW-1:0]     quo_q, quo_d, quo_sum;
  logic [IDX_W+6:0]  idx_ext;

  assign step = s1_valid_q && advance;

  for (genvar i = 0; i < LINE_PIXELS; i++) begin : g_ring
    logic [SW-1:0] cell_in;
    if (i == LINE_PIXELS - 1) begin : g_tail
      assign cell_in = smooth;
    end else begin : g_body
      assign cell_in = ring[i+1];
    end
    lsfa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(step),
      .data_i (cell_in),
      .data_o (ring[i])
    );
  end

  assign mac      = {1'b0, s1_sample_q, 3'b000} + 14'(s1_sample_q) + 14'(ring[0]);
  assign div_prod = 30'(mac) * 30'(lsfa_pkg::DIV10_MUL);
  assign smooth   = div_prod[lsfa_pkg::DIV10_SHIFT +: SW];

  assign is_end = (idx_q == LAST_IDX);
  assign idx_d  = is_end ? '0 : idx_q + 1'b1;
  assign in_win = (32'(idx_q) >= 32'(WINDOW_FIRST)) && (32'(idx_q) < 32'(WINDOW_LIMIT));

  assign win_min = (in_win && (smooth < run_min_q)) ? smooth : run_min_q;
  assign win_max = (in_win && (smooth > run_max_q)) ? smooth : run_max_q;
  assign run_min_d = is_end ? lsfa_pkg::MIN_CAP : win_min;
  assign run_max_d = is_end ? '0 : win_max;

  // running quotient and remainder of the raw sum by the line length
  assign rem_full  = s1_sample_q - SW'(s1_qs_q * LINE_PIXELS);
  assign rem_sum   = {1'b0, rem_q} + {1'b0, rem_full[IDX_W-1:0]};
  assign rem_carry = (rem_sum >= (IDX_W+1)'(LINE_PIXELS));
  assign quo_sum   = quo_q + SW'(s1_qs_q) + SW'(rem_carry);
  assign rem_d     = is_end ? '0
                   : (rem_carry ? IDX_W'(rem_sum - (IDX_W+1)'(LINE_PIXELS))
                                : rem_sum[IDX_W-1:0]);
  assign quo_d     = is_end ? '0 : quo_sum;
  assign idx_ext   = {7'd0, idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      run_min_q <= lsfa_pkg::MIN_CAP;
      run_max_q <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
    end else if (step) begin
      idx_q     <= idx_d;
      run_min_q <= run_min_d;
      run_max_q <= run_max_d;
      rem_q     <= rem_d;
      quo_q     <= quo_d;
    end
  end

  logic                          s2_valid_q;
  logic [lsfa_pkg::INDEX_W-1:0]  s2_index_q;
  logic                          s2_start_q;
  logic [SW-1:0]                 s2_smooth_q;
  logic                          s2_end_q;
  logic [SW-1:0]                 s2_avg_q;
  logic [SW-1:0]                 s2_min_q;
  logic [SW-1:0]                 s2_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_index_q  <= idx_ext[6:0];
      s2_start_q  <= (idx_q == '0) || (idx_q == IDX_W'(1));
      s2_smooth_q <= smooth;
      s2_end_q    <= is_end;
      s2_avg_q    <= is_end ? quo_sum : '0;
      s2_min_q    <= is_end ? win_min : '0;
      s2_max_q    <= is_end ? win_max : '0;
    end
  end

  // stage 3: exposure adjustment and output register
  logic [lsfa_pkg::ITV_W-1:0] itv_q, itv_d, itv_adj;

  lsfa_exposure u_exposure (
    .cfg_i     (cfg_q),
    .average_i (s2_avg_q),
    .interval_i(itv_q),
    .interval_o(itv_adj)
  );

  assign itv_d = (s2_valid_q && s2_end_q) ? itv_adj : itv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itv_q       <= lsfa_pkg::INTERVAL_START;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      itv_q       <= itv_d;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pixel_index_o       <= s2_index_q;
      start_pulse_o       <= s2_start_q;
      smoothed_pixel_o    <= s2_smooth_q;
      line_end_o          <= s2_end_q;
      line_average_o      <= s2_avg_q;
      exposure_interval_o <= itv_d;
      window_min_o        <= s2_min_q;
      window_max_o        <= s2_max_q;
    end
  end

endmodule

// ===== design/lsfa_cell.sv =====
// One cell of the line store ring: holds one smoothed pixel, shifts toward the head.
module lsfa_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic [lsfa_pkg::SAMPLE_W-1:0] data_i,
  output logic [lsfa_pkg::SAMPLE_W-1:0] data_o
);

  logic [lsfa_pkg::SAMPLE_W-1:0] pix_q;
  logic [lsfa_pkg::SAMPLE_W-1:0] pix_d;

  assign pix_d  = shift_i ? data_i : pix_q;
  assign data_o = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else begin
      pix_q <= pix_d;
    end
  end

endmodule

// ===== design/lsfa_exposure.sv =====
// Exposure interval adjustment from the line average.
module lsfa_exposure (
  input  lsfa_pkg::cfg_t                cfg_i,
  input  logic [lsfa_pkg::SAMPLE_W-1:0] average_i,
  input  logic [lsfa_pkg::ITV_W-1:0]    interval_i,
  output logic [lsfa_pkg::ITV_W-1:0]    interval_o
);

  logic [lsfa_pkg::ITV_W:0]   grow;
  logic [lsfa_pkg::ITV_W-1:0] shrink_coarse;
  logic [lsfa_pkg::ITV_W-1:0] shrink_fine;

  assign grow          = {1'b0, interval_i} + {1'b0, cfg_i.fine_step};
  assign shrink_coarse = (interval_i > cfg_i.coarse_step) ? interval_i - cfg_i.coarse_step : '0;
  assign shrink_fine   = (interval_i > cfg_i.fine_step) ? interval_i - cfg_i.fine_step : '0;

  always_comb begin
    interval_o = interval_i;
    if (average_i < cfg_i.dark_level) begin
      if (interval_i < cfg_i.interval_ceiling) begin
        interval_o = grow[lsfa_pkg::ITV_W] ? '1 : grow[lsfa_pkg::ITV_W-1:0];
      end
    end else if (average_i > cfg_i.bright_level) begin
      if (interval_i > cfg_i.coarse_floor) begin
        interval_o = shrink_coarse;
      end else if (interval_i > cfg_i.fine_floor) begin
        interval_o = shrink_fine;
      end
    end
  end

endmodule

// ===== tb/sv/lsfa_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the line scan filter: mirrors the registers, predicts each pixel result, compares.
module lsfa_checker
  import lsfa_pkg::*;
#(
  parameter int LINE_PIXELS  = LINE_PIXELS_DEF,
  parameter int WINDOW_FIRST = WINDOW_FIRST_DEF,
  parameter int WINDOW_LIMIT = WINDOW_LIMIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [APB_AW-1:0]   paddr_i,
  input  logic [APB_DW-1:0]   pwdata_i,
  input  logic                pready_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [INDEX_W-1:0]  pixel_index_i,
  input  logic                start_pulse_i,
  input  logic [SAMPLE_W-1:0] smoothed_pixel_i,
  input  logic                line_end_i,
  input  logic [SAMPLE_W-1:0] line_average_i,
  input  logic [ITV_W-1:0]    exposure_interval_i,
  input  logic [SAMPLE_W-1:0] window_min_i,
  input  logic [SAMPLE_W-1:0] window_max_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int unsigned ITV_MAX    = (1 << ITV_W) - 1;

  typedef struct packed {
    logic [INDEX_W-1:0]  index;
    logic                start;
    logic [SAMPLE_W-1:0] smoothed;
    logic                line_end;
    logic [SAMPLE_W-1:0] average;
    logic [ITV_W-1:0]    interval;
    logic [SAMPLE_W-1:0] wmin;
    logic [SAMPLE_W-1:0] wmax;
  } pixel_result_t;

  cfg_t                cfg;
  logic [SAMPLE_W-1:0] line_mem [LINE_PIXELS];
  int unsigned         pixel_pos;
  int unsigned         sample_sum;
  int unsigned         exposure;
  int unsigned         run_min;
  int unsigned         run_max;
  pixel_result_t       expected_q [$];
  int                  mismatches;

  function automatic pixel_result_t filter_pixel(logic [SAMPLE_W-1:0] sample);
    pixel_result_t r;
    int unsigned   s;
    int unsigned   sm;
    int unsigned   avg;
    s  = 32'(sample);
    sm = (9 * s + 32'(line_mem[pixel_pos])) / 10;
    if (sm > SAMPLE_MAX) sm = SAMPLE_MAX;
    line_mem[pixel_pos] = sm[SAMPLE_W-1:0];
    sample_sum += s;
    if (pixel_pos >= WINDOW_FIRST && pixel_pos < WINDOW_LIMIT) begin
      if (sm < run_min) run_min = sm;
      if (sm > run_max) run_max = sm;
    end
    r          = '0;
    r.index    = pixel_pos[INDEX_W-1:0];
    r.start    = (pixel_pos < 2);
    r.smoothed = sm[SAMPLE_W-1:0];
    r.line_end = (pixel_pos == LINE_PIXELS - 1);
    if (r.line_end) begin
      avg = sample_sum / LINE_PIXELS;
      if (avg > SAMPLE_MAX) avg = SAMPLE_MAX;
      sample_sum = 0;
      if (avg < cfg.dark_level) begin
        if (exposure < cfg.interval_ceiling) begin
          exposure += 32'(cfg.fine_step);
          if (exposure > ITV_MAX) exposure = ITV_MAX;
        end
      end else if (avg > cfg.bright_level) begin
        if (exposure > cfg.coarse_floor)
          exposure = (exposure > cfg.coarse_step) ? exposure - 32'(cfg.coarse_step) : 0;
        else if (exposure > cfg.fine_floor)
          exposure = (exposure > cfg.fine_step) ? exposure - 32'(cfg.fine_step) : 0;
      end
      r.average = avg[SAMPLE_W-1:0];
      r.wmin    = run_min[SAMPLE_W-1:0];
      r.wmax    = run_max[SAMPLE_W-1:0];
      run_min   = 32'(MIN_CAP);
      run_max   = 0;
    end
    r.interval = exposure[ITV_W-1:0];
    pixel_pos  = (pixel_pos + 1) % LINE_PIXELS;
    return r;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got, int unsigned pix);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("pixel %0d: %s expected %0d, got %0d", pix, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      cfg = '{dark_level: DARK_LEVEL_RST, bright_level: BRIGHT_LEVEL_RST,
              interval_ceiling: INTERVAL_CEILING_RST, coarse_floor: COARSE_FLOOR_RST,
              fine_floor: FINE_FLOOR_RST, fine_step: FINE_STEP_RST,
              coarse_step: COARSE_STEP_RST};
      foreach (line_mem[i]) line_mem[i] = '0;
      pixel_pos  = 0;
      sample_sum = 0;
      exposure   = 32'(INTERVAL_START);
      run_min    = 32'(MIN_CAP);
      run_max    = 0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_AW-1:2])
          REG_DARK_LEVEL:       cfg.dark_level       = pwdata_i[SAMPLE_W-1:0];
          REG_BRIGHT_LEVEL:     cfg.bright_level     = pwdata_i[SAMPLE_W-1:0];
          REG_INTERVAL_CEILING: cfg.interval_ceiling = pwdata_i[ITV_W-1:0];
          REG_COARSE_FLOOR:     cfg.coarse_floor     = pwdata_i[ITV_W-1:0];
          REG_FINE_FLOOR:       cfg.fine_floor       = pwdata_i[ITV_W-1:0];
          REG_FINE_STEP:        cfg.fine_step        = pwdata_i[ITV_W-1:0];
          REG_COARSE_STEP:      cfg.coarse_step      = pwdata_i[ITV_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(filter_pixel(sample_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction at pixel %0d", pixel_index_i);
        end else begin
          want = expected_q.pop_front();
          check_field("pixel_index", 32'(want.index), 32'(pixel_index_i), 32'(want.index));
          check_field("start_pulse", 32'(want.start), 32'(start_pulse_i), 32'(want.index));
          check_field("smoothed_pixel", 32'(want.smoothed), 32'(smoothed_pixel_i),
                      32'(want.index));
          check_field("line_end", 32'(want.line_end), 32'(line_end_i), 32'(want.index));
          check_field("line_average", 32'(want.average), 32'(line_average_i),
                      32'(want.index));
          check_field("exposure_interval", 32'(want.interval), 32'(exposure_interval_i),
                      32'(want.index));
          check_field("window_min", 32'(want.wmin), 32'(window_min_i), 32'(want.index));
          check_field("window_max", 32'(want.wmax), 32'(window_max_i), 32'(want.index));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_q.size();
  end

endmodule

// ===== tb/sv/line_scan_filter_autoexposure_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the line scan filter: clock, reset, register setup, pixel stimulus, verdict.
module line_scan_filter_autoexposure_tb;
  import lsfa_pkg::*;

  localparam int LINE_LEN       = LINE_PIXELS_DEF;
  localparam int DIRECTED_ITEMS = 25;
  localparam int PHASE_COUNT    = 6;
  localparam int SEGMENT_ITEMS  = 224;
  localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + PHASE_COUNT * SEGMENT_ITEMS;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int DRAIN_CYCLES   = 8;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  localparam logic [SAMPLE_W-1:0] DIRECTED_SAMPLES [DIRECTED_ITEMS] = '{
    10'd0, 10'd1023, 10'd1, 10'd1022, 10'd341, 10'd682, 10'd512, 10'd511, 10'd1023, 10'd0,
    10'd1023, 10'd0, 10'd999, 10'd1000, 10'd1001, 10'd1023, 10'd0, 10'd256, 10'd768,
    10'd1023, 10'd1023, 10'd0, 10'd0, 10'd128, 10'd896
  };

  typedef enum int {
    LINE_UNIFORM, LINE_DARK, LINE_BRIGHT, LINE_MID, LINE_FLAT, LINE_STRIPED
  } line_style_e;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [APB_DW-1:0]   pwdata      = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] sample_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [INDEX_W-1:0]  pixel_index_o;
  logic                start_pulse_o;
  logic [SAMPLE_W-1:0] smoothed_pixel_o;
  logic                line_end_o;
  logic [SAMPLE_W-1:0] line_average_o;
  logic [ITV_W-1:0]    exposure_interval_o;
  logic [SAMPLE_W-1:0] window_min_o;
  logic [SAMPLE_W-1:0] window_max_o;

  int gap_pct   = 24;
  int stall_pct = 76;
  int sent      = 0;
  int fail_count;
  int pending;

  line_scan_filter_autoexposure i_dut (.*);

  lsfa_checker i_checker (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .in_valid_i, .in_ready_i(in_ready_o), .sample_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .pixel_index_i(pixel_index_o), .start_pulse_i(start_pulse_o),
    .smoothed_pixel_i(smoothed_pixel_o), .line_end_i(line_end_o),
    .line_average_i(line_average_o), .exposure_interval_i(exposure_interval_o),
    .window_min_i(window_min_o), .window_max_i(window_max_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic apb_write(logic [2:0] idx, logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // registers only change with the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_pixel(logic [SAMPLE_W-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (sent < TOTAL_ITEMS / 3) begin
      gap_pct   = 24;
      stall_pct = 76;
    end else if (sent < 2 * TOTAL_ITEMS / 3) begin
      gap_pct   = 76;
      stall_pct = 24;
    end else begin
      gap_pct   = 0;
      stall_pct = 0;
    end
  endtask

  initial begin : stimulus
    line_style_e         style;
    logic [SAMPLE_W-1:0] flat_level;
    logic [SAMPLE_W-1:0] value;
    int                  pos;
    int                  waited;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_SAMPLES[i]) send_pixel(DIRECTED_SAMPLES[i]);
    settle();
    apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      case (ph)
        0: begin
          // growth up to the 16-bit ceiling
          apb_write(REG_DARK_LEVEL, 32'd1023);
          apb_write(REG_BRIGHT_LEVEL, 32'd1023);
          apb_write(REG_INTERVAL_CEILING, 32'd65535);
          apb_write(REG_FINE_STEP, 32'd65535);
        end
        1: begin
          // fine shrink only
          apb_write(REG_DARK_LEVEL, 32'd0);
          apb_write(REG_BRIGHT_LEVEL, 32'd0);
          apb_write(REG_COARSE_FLOOR, 32'd65535);
          apb_write(REG_FINE_FLOOR, $urandom_range(3000));
          apb_write(REG_FINE_STEP, $urandom_range(40000, 1000));
        end
        2: begin
          // coarse shrink saturating at zero
          apb_write(REG_COARSE_FLOOR, 32'd0);
          apb_write(REG_FINE_FLOOR, 32'd0);
          apb_write(REG_COARSE_STEP, 32'd65535);
        end
        3: begin
          apb_write(REG_DARK_LEVEL, 32'd1023);
          apb_write(REG_BRIGHT_LEVEL, 32'd1023);
          apb_write(REG_INTERVAL_CEILING, $urandom_range(65535));
          apb_write(REG_FINE_STEP, $urandom_range(5000));
        end
        4: begin
          apb_write(REG_DARK_LEVEL, $urandom);
          apb_write(REG_BRIGHT_LEVEL, $urandom);
          apb_write(REG_INTERVAL_CEILING, $urandom);
          apb_write(REG_COARSE_FLOOR, $urandom);
          apb_write(REG_FINE_FLOOR, $urandom);
          apb_write(REG_FINE_STEP, $urandom);
          apb_write(REG_COARSE_STEP, $urandom);
        end
        default: begin
          apb_write(REG_DARK_LEVEL, 32'(DARK_LEVEL_RST));
          apb_write(REG_BRIGHT_LEVEL, 32'(BRIGHT_LEVEL_RST));
          apb_write(REG_INTERVAL_CEILING, 32'(INTERVAL_CEILING_RST));
          apb_write(REG_COARSE_FLOOR, 32'(COARSE_FLOOR_RST));
          apb_write(REG_FINE_FLOOR, 32'(FINE_FLOOR_RST));
          apb_write(REG_FINE_STEP, 32'(FINE_STEP_RST));
          apb_write(REG_COARSE_STEP, 32'(COARSE_STEP_RST));
        end
      endcase

      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        pos = sent % LINE_LEN;
        if (pos == 0 || n == 0) begin
          style      = line_style_e'($urandom_range(LINE_STRIPED));
          flat_level = $urandom_range(1) ? 10'd1023 : 10'd0;
        end
        case (style)
          LINE_DARK:    value = SAMPLE_W'($urandom_range(200));
          LINE_BRIGHT:  value = SAMPLE_W'($urandom_range(1023, 980));
          LINE_MID:     value = SAMPLE_W'($urandom_range(700, 400));
          LINE_FLAT:    value = flat_level;
          LINE_STRIPED: value = pos[0] ? SAMPLE_W'($urandom_range(1023, 1000))
                                       : SAMPLE_W'($urandom_range(23));
          default:      value = SAMPLE_W'($urandom_range(1023));
        endcase
        send_pixel(value);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lsfa_pkg.sv
design/lsfa_cell.sv
design/lsfa_exposure.sv
design/line_scan_filter_autoexposure.sv
tb/sv/lsfa_checker.sv
tb/sv/line_scan_filter_autoexposure_tb.sv
